### rtl/wed_pkg.sv
package wed_pkg;

	// default string capacity
	localparam int MAX_LEN_DEF = 64;

	localparam int SYM_W  = 8;
	localparam int COST_W = 8;
	localparam int DIST_W = 16;

	// item kinds carried in tuser
	typedef enum logic [1:0] {
		KIND_FIRST   = 2'd0,
		KIND_SECOND  = 2'd1,
		KIND_COMPUTE = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_INSERT  = 2'd0,
		REG_DELETE  = 2'd1,
		REG_REPLACE = 2'd2,
		REG_UNUSED  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic [COST_W-1:0] ins;
		logic [COST_W-1:0] del;
		logic [COST_W-1:0] rep;
	} costs_t;

	// one column element moving down the cell chain
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [SYM_W-1:0]  sym;
		logic [DIST_W-1:0] score;
	} wave_t;

	// saturating add of a cost to a score
	function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {{(DIST_W+1-COST_W){1'b0}}, b};
		return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
	endfunction

endpackage

### rtl/wed_cell.sv
module wed_cell
	import wed_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [SYM_W-1:0] wr_sym,
	input  logic             active,
	input  costs_t           costs,
	input  wave_t            up_wave,
	output wave_t            down_wave
);

	logic [SYM_W-1:0]  sym_q;
	logic [DIST_W-1:0] left_q;
	logic [DIST_W-1:0] diag_q;
	logic [DIST_W-1:0] next_score;
	logic [DIST_W-1:0] via_ins;
	logic [DIST_W-1:0] via_del;
	logic [DIST_W-1:0] via_rep;
	logic [DIST_W-1:0] best_id;
	logic              out_valid_q;
	wave_t             out_q;

	// symbol of the first string held by this row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			sym_q <= wr_sym;
		end
	end

	// recurrence for this row
	always_comb begin
		via_ins = sat_add(left_q, costs.ins);
		via_del = sat_add(up_wave.score, costs.del);
		via_rep = sat_add(diag_q, costs.rep);
		best_id = (via_ins < via_del) ? via_ins : via_del;
		if (up_wave.first) begin
			next_score = via_del;
		end else if (up_wave.sym == sym_q) begin
			next_score = diag_q;
		end else begin
			next_score = (via_rep < best_id) ? via_rep : best_id;
		end
	end

	// row state and hand-off to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= up_wave.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_wave.valid && active) begin
			left_q <= next_score;
			diag_q <= up_wave.score;
		end
		out_q.valid <= 1'b0;
		out_q.first <= up_wave.first;
		out_q.last  <= up_wave.last;
		out_q.sym   <= up_wave.sym;
		out_q.score <= active ? next_score : up_wave.score;
	end

	always_comb begin
		down_wave       = out_q;
		down_wave.valid = out_valid_q;
	end

endmodule

### rtl/wed_feed.sv
module wed_feed
	import wed_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
	input  logic [SYM_W-1:0]                    wr_sym,
	input  logic                                start,
	input  logic [$clog2(MAX_LEN+1)-1:0]        len,
	input  logic [COST_W-1:0]                   ins_cost,
	output wave_t                               wave
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [SYM_W-1:0]  mem [MAX_LEN];
	logic              run_q;
	logic [CW-1:0]     col_q;
	logic [CW-1:0]     col_prev;
	logic [DIST_W-1:0] top_q;
	logic              valid_s1;
	logic              first_s1;
	logic              last_s1;
	logic [SYM_W-1:0]  sym_s1;
	logic [DIST_W-1:0] score_s1;

	assign col_prev = col_q - CW'(1);

	// second string store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_sym;
		end
	end

	// column counter and top-row score
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= run_q;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && (col_q == len)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			col_q <= '0;
			top_q <= '0;
		end else if (run_q) begin
			col_q <= col_q + CW'(1);
			top_q <= sat_add(top_q, ins_cost);
		end
		first_s1 <= (col_q == '0);
		last_s1  <= (col_q == len);
		score_s1 <= top_q;
		sym_s1   <= mem[col_prev[AW-1:0]];
	end

	always_comb begin
		wave.valid = valid_s1;
		wave.first = first_s1;
		wave.last  = last_s1;
		wave.sym   = sym_s1;
		wave.score = score_s1;
	end

endmodule

### rtl/weighted_edit_distance.sv
// loads of either string are taken one transfer per cycle while the block is idle
// compute: the columns of the second string pass through the MAX_LEN cells of the
// chain; the last column's score goes to the pending result; input waits meanwhile
// compute after overflow skips the chain; its result goes to the output register once free
// reset: asynchronous, active low; costs return to 1, strings empty,
// overflow cleared, no result pending
module weighted_edit_distance
	import wed_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // symbol[7:0]
	input  logic [1:0]        s_tuser,   // kind[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // distance[15:0], overflow[16], zero fill
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [COST_W-1:0] cfg_data
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	state_t            state_q;
	state_t            state_next;
	costs_t            costs_q;
	logic [CW-1:0]     first_count_q;
	logic [CW-1:0]     second_count_q;
	logic              overflow_q;
	logic [DIST_W-1:0] res_dist_q;
	logic              res_ovf_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] out_dist_q;
	logic              out_ovf_q;
	logic              accept;
	kind_t             kind;
	logic              load_first;
	logic              load_second;
	logic              start;
	logic              out_load;
	logic              out_free;
	logic              first_full;
	logic              second_full;
	wave_t             chain [MAX_LEN+1];
	wave_t             tail;

	assign kind        = kind_t'(s_tuser);
	assign accept      = s_tvalid && s_tready;
	assign first_full  = (first_count_q == CW'(MAX_LEN));
	assign second_full = (second_count_q == CW'(MAX_LEN));
	assign load_first  = accept && (kind == KIND_FIRST) && !first_full;
	assign load_second = accept && (kind == KIND_SECOND) && !second_full;
	assign out_free    = !out_valid_q || m_tready;
	assign tail        = chain[MAX_LEN];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			costs_q.ins <= COST_W'(1);
			costs_q.del <= COST_W'(1);
			costs_q.rep <= COST_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INSERT:  costs_q.ins <= cfg_data;
				REG_DELETE:  costs_q.del <= cfg_data;
				REG_REPLACE: costs_q.rep <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (kind == KIND_COMPUTE)) begin
					state_next = overflow_q ? ST_WAIT : ST_RUN;
				end
			end
			ST_RUN: begin
				if (tail.valid && tail.last) begin
					state_next = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		start    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				start    = accept && (kind == KIND_COMPUTE) && !overflow_q;
			end
			ST_RUN: ;
			ST_WAIT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// string counts and overflow flag, cleared once the result is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			overflow_q     <= 1'b0;
		end else if (out_load) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			overflow_q     <= 1'b0;
		end else begin
			if (load_first) begin
				first_count_q <= first_count_q + CW'(1);
			end
			if (load_second) begin
				second_count_q <= second_count_q + CW'(1);
			end
			if (accept && (((kind == KIND_FIRST) && first_full) ||
					((kind == KIND_SECOND) && second_full))) begin
				overflow_q <= 1'b1;
			end
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && accept && (kind == KIND_COMPUTE)) begin
			res_dist_q <= '0;
			res_ovf_q  <= 1'b1;
		end else if ((state_q == ST_RUN) && tail.valid && tail.last) begin
			res_dist_q <= tail.score;
			res_ovf_q  <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dist_q <= res_dist_q;
			out_ovf_q  <= res_ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_ovf_q, out_dist_q};

	// column feeder with the second string
	wed_feed #(
		.MAX_LEN(MAX_LEN)
	) u_feed (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_second),
		.wr_addr (second_count_q[AW-1:0]),
		.wr_sym  (s_tdata),
		.start   (start),
		.len     (second_count_q),
		.ins_cost(costs_q.ins),
		.wave    (chain[0])
	);

	// one cell per symbol of the first string
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		wed_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (load_first && (first_count_q == CW'(k))),
			.wr_sym   (s_tdata),
			.active   (CW'(k) < first_count_q),
			.costs    (costs_q),
			.up_wave  (chain[k]),
			.down_wave(chain[k+1])
		);
	end

`ifndef SYNTHESIS
	a_tail_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> (state_q == ST_RUN))
		else $error("chain output outside a compute");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(first_count_q <= CW'(MAX_LEN)) && (second_count_q <= CW'(MAX_LEN)))
		else $error("string count beyond capacity");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] == '0))
		else $error("overflow result with nonzero distance");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> ((first_count_q == $past(first_count_q)) &&
			(second_count_q == $past(second_count_q))))
		else $error("string changed during compute");
`endif

endmodule

### tb/tb_weighted_edit_distance.sv
`timescale 1ns / 1ps

module tb_weighted_edit_distance;
	import wed_pkg::*;

	localparam int STR_CAP     = MAX_LEN_DEF;
	localparam int HALF_PERIOD = 6;
	// long enough to cover any compute job still in flight
	localparam int SETTLE      = 2 * STR_CAP + 16;
	localparam int HOLD_CYCLES = 400;
	localparam int RUN_LIMIT   = 500000 * 2 * HALF_PERIOD;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic              ovf;
	} dist_result_t;

	// golden copy of both strings and the costs, plus the results still owed
	class dist_scoreboard;
		logic [COST_W-1:0] ins_cost, del_cost, rep_cost;
		logic [SYM_W-1:0]  first_str [STR_CAP];
		logic [SYM_W-1:0]  second_str[STR_CAP];
		int                first_len, second_len;
		bit                ovf_seen;
		dist_result_t      owed_q[$];
		int                mismatches;

		function new();
			ins_cost   = 8'd1;
			del_cost   = 8'd1;
			rep_cost   = 8'd1;
			first_len  = 0;
			second_len = 0;
			ovf_seen   = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [COST_W-1:0] val);
			case (idx)
				REG_INSERT:  ins_cost = val;
				REG_DELETE:  del_cost = val;
				REG_REPLACE: rep_cost = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function int clip16(int v);
			return (v > 65535) ? 65535 : v;
		endfunction

		function int min3(int a, int b, int c);
			int m;
			m = (a < b) ? a : b;
			return (m < c) ? m : c;
		endfunction

		// single-row dynamic program, every partial cost clipped
		function logic [DIST_W-1:0] weighted_distance();
			int row[STR_CAP+1];
			int diag, up, nxt;
			row[0] = 0;
			for (int j = 1; j <= second_len; j++)
				row[j] = clip16(row[j-1] + ins_cost);
			for (int i = 1; i <= first_len; i++) begin
				diag   = row[0];
				row[0] = clip16(diag + del_cost);
				for (int j = 1; j <= second_len; j++) begin
					up = row[j];
					if (first_str[i-1] == second_str[j-1])
						nxt = diag;
					else
						nxt = min3(clip16(row[j-1] + ins_cost), clip16(up + del_cost),
							clip16(diag + rep_cost));
					diag   = up;
					row[j] = nxt;
				end
			end
			return row[second_len][DIST_W-1:0];
		endfunction

		function void note_input(kind_t k, logic [SYM_W-1:0] sym);
			dist_result_t r;
			case (k)
				KIND_FIRST: begin
					if (first_len >= STR_CAP) ovf_seen = 1'b1;
					else begin
						first_str[first_len] = sym;
						first_len++;
					end
				end
				KIND_SECOND: begin
					if (second_len >= STR_CAP) ovf_seen = 1'b1;
					else begin
						second_str[second_len] = sym;
						second_len++;
					end
				end
				KIND_COMPUTE: begin
					r.distance = ovf_seen ? '0 : weighted_distance();
					r.ovf      = ovf_seen;
					owed_q     = {owed_q, r};
					first_len  = 0;
					second_len = 0;
					ovf_seen   = 1'b0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [DIST_W-1:0] distance, logic ovf);
			dist_result_t r;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: distance %0d overflow %0b", distance, ovf);
				return;
			end
			r = owed_q.pop_front();
			if (distance !== r.distance || ovf !== r.ovf) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected distance %0d overflow %0b, got %0d %0b",
						r.distance, r.ovf, distance, ovf);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // symbol[7:0]
	logic [1:0]        s_tuser;   // kind[1:0]
	logic              m_tvalid;
	logic              m_tready;
	logic [23:0]       m_tdata;   // distance[15:0], overflow[16], zero fill
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [COST_W-1:0] cfg_data;

	dist_scoreboard sb;
	int  items_sent;
	int  computes_sent;
	bit  send_calm;
	bit  recv_calm;
	bit  hold_request;

	weighted_edit_distance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// run limit
	initial begin
		#RUN_LIMIT;
		$display("tb_weighted_edit_distance failed");
		$finish;
	end

	// one symbol or command transfer on the input stream
	task automatic send_item(input kind_t k, input logic [SYM_W-1:0] sym);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= sym;
		do @(posedge clk); while (!s_tready);
		sb.note_input(k, sym);
		if (k != KIND_NONE) items_sent++;
		if (k == KIND_COMPUTE) computes_sent++;
	endtask

	// register write; valid stays up for back-to-back writes
	task automatic write_reg(input reg_idx_t idx, input logic [COST_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	// stop sending, let every result drain and the block settle
	task automatic drain_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] ins, input logic [7:0] del,
			input logic [7:0] rep, input bit touch_unused);
		drain_idle();
		write_reg(REG_REPLACE, rep);
		if (touch_unused) write_reg(REG_UNUSED, 8'($urandom));
		write_reg(REG_INSERT, ins);
		write_reg(REG_DELETE, del);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [SYM_W-1:0] pick_sym(input logic [SYM_W-1:0] base, input bit wide);
		if (wide) return 8'($urandom);
		return base + 8'($urandom_range(0, 3));
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) return $urandom_range(0, 6);
		if (r < 98) return $urandom_range(7, STR_CAP);
		return STR_CAP;
	endfunction

	// load two strings interleaved, with stray ignored items, then compute
	task automatic send_strings(input int len_a, input int len_b);
		logic [SYM_W-1:0] a_q[$];
		logic [SYM_W-1:0] b_q[$];
		logic [SYM_W-1:0] base;
		bit               wide;
		bit               derived;
		int               ia, ib, r;
		base    = 8'($urandom);
		wide    = ($urandom_range(0, 3) == 0);
		derived = ($urandom_range(0, 1) == 1) && (len_b <= STR_CAP);
		repeat (len_a) a_q = {a_q, pick_sym(base, wide)};
		if (derived) begin
			// second string as a lightly edited copy of the first
			foreach (a_q[k]) begin
				r = $urandom_range(0, 9);
				if (r == 9) b_q = {b_q, pick_sym(base, wide)};
				if (r == 6) b_q = {b_q, pick_sym(base, wide)};
				else if (r != 7) b_q = {b_q, a_q[k]};
				if (r == 8) b_q = {b_q, pick_sym(base, wide)};
			end
			while (b_q.size() > STR_CAP) void'(b_q.pop_back());
		end else begin
			repeat (len_b) b_q = {b_q, pick_sym(base, wide)};
		end
		ia = 0;
		ib = 0;
		while (ia < a_q.size() || ib < b_q.size()) begin
			if ($urandom_range(0, 11) == 0) send_item(KIND_NONE, 8'($urandom));
			if (ib >= b_q.size() || (ia < a_q.size() && $urandom_range(0, 1) == 1)) begin
				send_item(KIND_FIRST, a_q[ia]);
				ia++;
			end else begin
				send_item(KIND_SECOND, b_q[ib]);
				ib++;
			end
		end
		send_item(KIND_COMPUTE, 8'($urandom));
	endtask

	task automatic random_phase(input int quota);
		int target, first_compute, la, lb, r;
		target        = items_sent + quota;
		first_compute = computes_sent;
		while (items_sent < target || computes_sent - first_compute < 4) begin
			send_calm = ($urandom_range(0, 4) == 0);
			r  = $urandom_range(0, 99);
			la = pick_len();
			lb = pick_len();
			if (r < 2) la = STR_CAP + $urandom_range(1, 3);
			else if (r < 4) lb = STR_CAP + $urandom_range(1, 3);
			else if (r < 5) begin
				la = STR_CAP + 1;
				lb = STR_CAP + 1;
			end else if (r < 10) begin
				la = 0;
				lb = 0;
			end else if (r < 15) begin
				repeat ($urandom_range(1, 3)) send_item(KIND_NONE, 8'($urandom));
			end
			send_strings(la, lb);
		end
		send_calm = 1'b0;
	endtask

	// receiver holds off for a long stretch while short jobs keep coming
	task automatic stall_burst();
		hold_request = 1'b1;
		send_calm    = 1'b1;
		repeat (6) begin
			send_item(KIND_FIRST, 8'($urandom));
			send_item(KIND_SECOND, 8'($urandom));
			send_item(KIND_COMPUTE, 8'h00);
		end
		send_calm = 1'b0;
	endtask

	// result receiver
	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				if ($urandom_range(0, 9) == 0) recv_calm = !recv_calm;
				gap = recv_calm ? 0 : $urandom_range(0, 13);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// result monitor
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata[15:0], m_tdata[16]);
		end
	end

	// stimulus
	initial begin
		sb            = new();
		items_sent    = 0;
		computes_sent = 0;
		send_calm     = 1'b0;
		recv_calm     = 1'b0;
		hold_request  = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = KIND_FIRST;
		cfg_valid     = 1'b0;
		cfg_index     = REG_INSERT;
		cfg_data      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty strings, single deletes and inserts, match, replace, ignored kind
		send_item(KIND_COMPUTE, 8'hFF);
		send_item(KIND_FIRST, 8'h00);
		send_item(KIND_COMPUTE, 8'h00);
		send_item(KIND_SECOND, 8'hFF);
		send_item(KIND_COMPUTE, 8'h00);
		send_item(KIND_FIRST, 8'hAA);
		send_item(KIND_SECOND, 8'hAA);
		send_item(KIND_COMPUTE, 8'h00);
		send_item(KIND_FIRST, 8'h55);
		send_item(KIND_SECOND, 8'hAA);
		send_item(KIND_COMPUTE, 8'h00);
		send_item(KIND_NONE, 8'hFF);
		send_item(KIND_FIRST, 8'h01);
		send_item(KIND_NONE, 8'h00);
		send_item(KIND_SECOND, 8'h02);
		send_item(KIND_FIRST, 8'hFF);
		send_item(KIND_COMPUTE, 8'hFF);
		send_item(KIND_COMPUTE, 8'h00);

		random_phase(80);

		configure(8'd255, 8'd255, 8'd255, 1'b0);
		stall_burst();
		random_phase(80);

		configure(8'd0, 8'd0, 8'd0, 1'b1);
		random_phase(80);

		// replace dearer than delete plus insert
		configure(8'd5, 8'd9, 8'd200, 1'b0);
		random_phase(80);

		configure(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		random_phase(80);

		configure(8'd0, 8'd255, 8'd128, 1'b0);
		random_phase(40);

		drain_idle();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_weighted_edit_distance passed");
		else
			$display("tb_weighted_edit_distance failed");
		$finish;
	end

endmodule

### files.f
rtl/wed_pkg.sv
rtl/wed_cell.sv
rtl/wed_feed.sv
rtl/weighted_edit_distance.sv
tb/tb_weighted_edit_distance.sv
